// ----- design/pida_pkg.sv -----
// Shared types and constants for the positional insert/delete list.
package pida_pkg;

  // Storage word width and default list depth
  localparam int unsigned DataW    = 32;
  localparam int unsigned DepthDef = 16;

  // Command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // Per-cycle shift control broadcast to every cell
  typedef struct packed {
    logic ins_en;   // shift up from the position, load new value there
    logic del_en;   // shift down into the position and above
  } cell_ctrl_t;

endpackage

// ----- design/pida_cell.sv -----
// One storage cell of the list: holds one entry and trades it with its neighbors.
module pida_cell #(
  parameter int unsigned PosW = 5,
  parameter int unsigned Idx  = 0
) (
  input  logic                        clk_i,
  input  pida_pkg::cell_ctrl_t        ctrl_i,
  input  logic [PosW-1:0]             pos_i,
  input  logic [pida_pkg::DataW-1:0]  ins_value_i,
  input  logic [pida_pkg::DataW-1:0]  left_i,    // entry of the cell one below
  input  logic [pida_pkg::DataW-1:0]  right_i,   // entry of the cell one above
  output logic [pida_pkg::DataW-1:0]  value_o,
  output logic [pida_pkg::DataW-1:0]  rd_o       // own entry when selected, else zero
);
  import pida_pkg::*;

  localparam logic [PosW-1:0] MyIdx = PosW'(Idx);

  logic [DataW-1:0] value_q, value_d;
  logic             above, at;

  assign above = (MyIdx > pos_i);
  assign at    = (MyIdx == pos_i);

  // Next entry: take a neighbor on a shift, the new value at the insert slot
  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins_en) begin
      if (at) begin
        value_d = ins_value_i;
      end else if (above) begin
        value_d = left_i;
      end
    end else if (ctrl_i.del_en) begin
      if (at || above) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign rd_o    = at ? value_q : '0;

endmodule

// ----- design/positional_insert_delete_array.sv -----
// Top level of the positional insert/delete list: control, count and cell row.
//
// Usage: present cmd_i, position_i and item_value_i with start_i high. An item
// is taken at a rising edge where start_i is high and busy_o is low; busy_o
// stays low, so a command may be issued in every cycle.
// Commands: insert at a position from 0 to count, delete at a position below
// count (returns the removed entry), read at a position below count, clear.
// Result: done_o pulses for one cycle, in the cycle after the command is taken,
// with status_o, out_value_o and entry_count_o valid in that cycle. The
// receiver cannot stall; a result not taken in its cycle is gone.
// Throughput: one command per cycle. Every cell of the row shifts in the same
// edge, so insert and delete cost no more than a read; the read path is a
// one-hot select over the DEPTH cells.
// Reset: rst_ni (asynchronous, active low) empties the list and drops done_o.
// Entry contents are not cleared; only positions below the count are read.
module positional_insert_delete_array #(
  parameter int unsigned DEPTH = pida_pkg::DepthDef,
  parameter int unsigned PosW  = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  cmd_i,
  input  logic [PosW-1:0]             position_i,
  input  logic [pida_pkg::DataW-1:0]  item_value_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [pida_pkg::DataW-1:0]  out_value_o,
  output logic [PosW-1:0]             entry_count_o
);
  import pida_pkg::*;

  localparam logic [PosW-1:0] Full = PosW'(DEPTH);

  logic             done_q, done_d;
  logic [PosW-1:0]  count_q, count_d;
  status_e          status_q, status_d;
  logic [DataW-1:0] out_value_q, out_value_d;

  cmd_e             cmd;
  logic             accept;
  logic             pos_in_list;   // position below count
  logic             pos_ins_ok;    // position at or below count
  cell_ctrl_t       ctrl;
  logic [DataW-1:0] rd_data;

  logic [DataW-1:0] cell_value [DEPTH];
  logic [DataW-1:0] cell_rd    [DEPTH];

  assign busy_o      = 1'b0;
  assign accept      = start_i && !busy_o;
  assign cmd         = cmd_e'(cmd_i);
  assign pos_in_list = (position_i < count_q);
  assign pos_ins_ok  = (position_i <= count_q);

  // Command decode: shift controls, status, returned value, new count
  always_comb begin
    ctrl        = '0;
    status_d    = ST_OK;
    out_value_d = '0;
    count_d     = count_q;
    if (accept) begin
      case (cmd)
        CMD_INSERT: begin
          if (!pos_ins_ok) begin
            status_d = ST_INVALID;
          end else if (count_q == Full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.ins_en = 1'b1;
            count_d     = count_q + PosW'(1);
          end
        end
        CMD_DELETE: begin
          if (!pos_in_list) begin
            status_d = ST_INVALID;
          end else begin
            ctrl.del_en = 1'b1;
            out_value_d = rd_data;
            count_d     = count_q - PosW'(1);
          end
        end
        CMD_READ: begin
          if (!pos_in_list) begin
            status_d = ST_INVALID;
          end else begin
            out_value_d = rd_data;
          end
        end
        CMD_CLEAR: begin
          count_d = '0;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  assign done_d = accept;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q  <= done_d;
      count_q <= count_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    out_value_q <= out_value_d;
  end

  // Row of cells; the ends see their own entry as the missing neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DataW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = cell_value[g];
    end else begin : g_mid_l
      assign left = cell_value[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = cell_value[g];
    end else begin : g_mid_r
      assign right = cell_value[g+1];
    end

    pida_cell #(
      .PosW (PosW),
      .Idx  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .pos_i       (position_i),
      .ins_value_i (item_value_i),
      .left_i      (left),
      .right_i     (right),
      .value_o     (cell_value[g]),
      .rd_o        (cell_rd[g])
    );
  end

  // One-hot read select: at most one cell drives a nonzero word
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_value_o   = out_value_q;
  assign entry_count_o = count_q;

endmodule
